// ===== rtl/shift_jis_to_utf8_converter_assert.svh =====
`ifndef SHIFT_JIS_TO_UTF8_CONVERTER_ASSERT_SVH
`define SHIFT_JIS_TO_UTF8_CONVERTER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define SJU_AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define SJU_AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sju_pkg.sv =====
package sju_pkg;

    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int IDX_W           = 14;
    localparam int CP_W            = 16;
    localparam int BYTE_W          = 8;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam logic [3:0] NIB_LEAD_8 = 4'h8;
    localparam logic [3:0] NIB_LEAD_9 = 4'h9;
    localparam logic [3:0] NIB_LEAD_E = 4'hE;

    localparam logic [IDX_W-1:0] BASE_8 = 14'h0100;
    localparam logic [IDX_W-1:0] BASE_9 = 14'h1100;
    localparam logic [IDX_W-1:0] BASE_E = 14'h2100;

    localparam logic [CP_W-1:0]   CP_ONE_LIMIT = 16'h0080;
    localparam logic [CP_W-1:0]   CP_TWO_LIMIT = 16'h0800;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2   = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3   = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_CONT    = 8'h80;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    typedef struct packed {
        logic [1:0]                  n;
        logic [2:0][BYTE_W-1:0]      b;
    } t_utf8;

    function automatic t_utf8 utf8_encode(input logic [CP_W-1:0] cp);
        t_utf8 e;
        e = '0;
        if (cp < CP_ONE_LIMIT) begin
            e.n    = 2'd1;
            e.b[0] = cp[7:0];
        end else if (cp < CP_TWO_LIMIT) begin
            e.n    = 2'd2;
            e.b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            e.b[1] = UTF8_CONT | {2'b00, cp[5:0]};
        end else begin
            e.n    = 2'd3;
            e.b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            e.b[1] = UTF8_CONT | {2'b00, cp[11:6]};
            e.b[2] = UTF8_CONT | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== rtl/shift_jis_to_utf8_converter.sv =====
// channel | direction | handshake             | payload
// input   | in        | i_valid / o_stall     | operation byte_in end_of_stream entry_index/value
// output  | out       | o_valid / i_stall     | utf8_byte last_of_char
//
// one input item per cycle while o_stall is low; a table read is registered in the ram, then the
// character register sends one utf8 byte per cycle while i_stall is low (1 to 3 bytes per char)
// sustained rate is set by the output port
// synchronous active-low reset clears control state; the table is not cleared
// a one-entry skid behind the ram keeps a read that lands while the character register is busy
`include "shift_jis_to_utf8_converter_assert.svh"

module shift_jis_to_utf8_converter import sju_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_end_of_stream,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [CP_W-1:0]   i_entry_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_utf8_byte,
    output logic              o_last_of_char
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   accept;
    logic                   take;
    logic                   wr_en;
    t_lookup                look;
    logic                   rd_oob;
    logic                   rd_en;
    logic [CP_W-1:0]        rdata;
    logic [CP_W-1:0]        cp_s1;
    logic [CP_W-1:0]        cp_src;
    t_utf8                  enc;
    logic                   c_free;
    logic                   c_load;

    logic                   r_s1_valid;
    logic                   r_s1_oob;
    logic                   r_k_valid;
    logic [CP_W-1:0]        r_k_cp;
    logic                   r_c_valid;
    logic [1:0]             r_c_left;
    logic [2:0][BYTE_W-1:0] r_c_bytes;

    assign o_stall = r_k_valid || (r_s1_valid && !c_free);
    assign accept  = i_valid && !o_stall;
    assign take    = accept && (i_operation == OP_CONVERT);
    assign wr_en   = accept && (i_operation == OP_WRITE)
                     && (32'(i_entry_index) < TABLE_DEPTH);

    sju_lead u_lead (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_byte_in       (i_byte_in),
        .i_end_of_stream (i_end_of_stream),
        .o_look          (look)
    );

    assign rd_oob = 32'(look.idx) >= TABLE_DEPTH;
    assign rd_en  = look.valid && !rd_oob;

    sju_ram #(
        .WIDTH (CP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_re    (rd_en),
        .i_raddr (AW'(look.idx)),
        .o_rdata (rdata)
    );

    assign cp_s1  = r_s1_oob ? '0 : rdata;
    assign cp_src = r_k_valid ? r_k_cp : cp_s1;
    assign enc    = utf8_encode(cp_src);
    assign c_free = !r_c_valid || ((r_c_left == 2'd1) && !i_stall);
    assign c_load = (r_k_valid || r_s1_valid) && c_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_k_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_c_left   <= 2'd0;
        end else begin
            r_s1_valid <= look.valid;
            if (r_s1_valid && !c_free) begin
                r_k_valid <= 1'b1;
            end else if (r_k_valid && c_free) begin
                r_k_valid <= 1'b0;
            end
            if (c_load) begin
                r_c_valid <= 1'b1;
                r_c_left  <= enc.n;
            end else if (r_c_valid && !i_stall) begin
                r_c_valid <= (r_c_left != 2'd1);
                r_c_left  <= r_c_left - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_oob <= rd_oob;
        if (r_s1_valid && !c_free) begin
            r_k_cp <= cp_s1;
        end
        if (c_load) begin
            r_c_bytes <= enc.b;
        end else if (r_c_valid && !i_stall) begin
            r_c_bytes <= {{BYTE_W{1'b0}}, r_c_bytes[2], r_c_bytes[1]};
        end
    end

    assign o_valid        = r_c_valid;
    assign o_utf8_byte    = r_c_bytes[0];
    assign o_last_of_char = (r_c_left == 2'd1);

    `SJU_AST_IMP(a_skid_excl, i_clk, i_rst_n, r_k_valid, !r_s1_valid, "skid and read stage both full")
    `SJU_AST_IMP(a_char_left, i_clk, i_rst_n, r_c_valid, r_c_left != 2'd0, "char register with no bytes")
    `SJU_AST_NXT(a_skid_bypass, i_clk, i_rst_n, r_s1_valid && c_free, !r_k_valid, "skid filled while free")

endmodule

// ===== rtl/sju_ram.sv =====
module sju_ram import sju_pkg::*; #(
    parameter int WIDTH = CP_W,
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sju_lead.sv =====
module sju_lead import sju_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_end_of_stream,
    output t_lookup           o_look
);

    logic             r_pending;
    logic [IDX_W-1:0] r_base;
    logic             n_pending;
    logic [IDX_W-1:0] n_base;
    logic [IDX_W-1:0] lead_base;
    t_lookup          look;

    always_comb begin
        case (i_byte_in[7:4])
            NIB_LEAD_8: lead_base = BASE_8;
            NIB_LEAD_9: lead_base = BASE_9;
            NIB_LEAD_E: lead_base = BASE_E;
            default:    lead_base = '0;
        endcase
    end

    always_comb begin
        n_pending  = r_pending;
        n_base     = r_base;
        look.valid = 1'b0;
        look.idx   = {{(IDX_W-BYTE_W){1'b0}}, i_byte_in};
        if (i_take) begin
            if (r_pending) begin
                look.valid = 1'b1;
                look.idx   = r_base + {{(IDX_W-BYTE_W){1'b0}}, i_byte_in};
                n_pending  = 1'b0;
                n_base     = '0;
            end else if (lead_base != '0) begin
                if (!i_end_of_stream) begin
                    n_pending = 1'b1;
                    n_base    = lead_base + {2'b00, i_byte_in[3:0], 8'h00};
                end
            end else begin
                look.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_base    <= '0;
        end else begin
            r_pending <= n_pending;
            r_base    <= n_base;
        end
    end

    assign o_look = look;

endmodule

// ===== sim/sju_utf8_checker.sv =====
module sju_utf8_checker import sju_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_operation,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_end_of_stream,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [CP_W-1:0]   i_entry_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_utf8_byte,
    input  logic              i_last_of_char,
    output int                o_fail_count,
    output int                o_bytes_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] utf8_byte;
        logic              last_of_char;
    } t_utf8_out;

    logic [CP_W-1:0]  code_tab [TABLE_DEPTH_DEF];
    logic             lead_held = 1'b0;
    logic [IDX_W-1:0] lead_base = '0;
    logic [IDX_W-1:0] lead_start;
    t_utf8_out        utf8_expected [$];
    t_utf8_out        want;
    int               fails = 0;

    initial begin
        o_fail_count    = 0;
        o_bytes_pending = 0;
    end

    function automatic logic [IDX_W-1:0] base_of_lead(input logic [3:0] nib);
        case (nib)
            NIB_LEAD_8: return BASE_8;
            NIB_LEAD_9: return BASE_9;
            NIB_LEAD_E: return BASE_E;
            default:    return '0;
        endcase
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last);
        utf8_expected.push_back({b, last});
    endfunction

    // split one code point into its utf8 bytes
    function automatic void queue_char(input logic [CP_W-1:0] cp);
        if (cp < 16'h0080) begin
            push_byte(cp[7:0], 1'b1);
        end else if (cp < 16'h0800) begin
            push_byte({3'b110, cp[10:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, 1'b1);
        end else begin
            push_byte({4'b1110, cp[15:12]}, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_WRITE) begin
                    code_tab[i_entry_index] = i_entry_value;
                end else if (lead_held) begin
                    queue_char(code_tab[lead_base + {{(IDX_W-BYTE_W){1'b0}}, i_byte_in}]);
                    lead_held = 1'b0;
                    lead_base = '0;
                end else begin
                    lead_start = base_of_lead(i_byte_in[7:4]);
                    if (lead_start != '0) begin
                        if (!i_end_of_stream) begin
                            lead_held = 1'b1;
                            lead_base = lead_start + {2'b00, i_byte_in[3:0], 8'h00};
                        end
                    end else begin
                        queue_char(code_tab[{{(IDX_W-BYTE_W){1'b0}}, i_byte_in}]);
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (utf8_expected.size() == 0) begin
                    $error("utf8_byte %h arrived with nothing expected", i_utf8_byte);
                    fails++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (i_utf8_byte !== want.utf8_byte) begin
                        $error("utf8_byte: expected %h, got %h", want.utf8_byte, i_utf8_byte);
                        fails++;
                    end
                    if (i_last_of_char !== want.last_of_char) begin
                        $error("last_of_char: expected %b, got %b",
                               want.last_of_char, i_last_of_char);
                        fails++;
                    end
                end
            end
        end
        o_fail_count    <= fails;
        o_bytes_pending <= utf8_expected.size();
    end

endmodule

// ===== sim/tb_shift_jis_to_utf8_converter.sv =====
module tb_shift_jis_to_utf8_converter;
    import sju_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_operation;
    logic [BYTE_W-1:0] i_byte_in;
    logic              i_end_of_stream;
    logic [IDX_W-1:0]  i_entry_index;
    logic [CP_W-1:0]   i_entry_value;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_utf8_byte;
    logic              o_last_of_char;

    int  fail_count;
    int  bytes_pending;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  items_sent     = 0;
    int  quiet_cycles   = 0;
    int  hold_cnt       = 0;
    logic hold_req      = 1'b0;
    bit  table_loaded [TABLE_DEPTH_DEF];

    always #6 i_clk = ~i_clk;

    shift_jis_to_utf8_converter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_byte_in       (i_byte_in),
        .i_end_of_stream (i_end_of_stream),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_utf8_byte     (o_utf8_byte),
        .o_last_of_char  (o_last_of_char)
    );

    sju_utf8_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_operation     (i_operation),
        .i_byte_in       (i_byte_in),
        .i_end_of_stream (i_end_of_stream),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_utf8_byte     (o_utf8_byte),
        .i_last_of_char  (o_last_of_char),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    // receiver: random stalls, one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt < LONG_HOLD) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b, input logic eos,
                             input logic [IDX_W-1:0] idx, input logic [CP_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_byte_in       <= b;
        i_end_of_stream <= eos;
        i_entry_index   <= idx;
        i_entry_value   <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [CP_W-1:0] val);
        send_item(OP_WRITE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), idx, val);
        table_loaded[idx] = 1'b1;
    endtask

    task automatic convert(input logic [BYTE_W-1:0] b, input logic eos);
        send_item(OP_CONVERT, b, eos, IDX_W'($urandom_range(16383)),
                  CP_W'($urandom_range(65535)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [CP_W-1:0] rand_cp();
        case ($urandom_range(4))
            0: return CP_W'($urandom_range(16'h007F));
            1: return CP_W'($urandom_range(16'h07FF, 16'h0080));
            2, 3: return CP_W'($urandom_range(16'hFFFF, 16'h0800));
            default: begin
                case ($urandom_range(5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] lead_index(input logic [BYTE_W-1:0] lead,
                                                    input logic [BYTE_W-1:0] trail);
        logic [IDX_W-1:0] base;
        case (lead[7:4])
            NIB_LEAD_8: base = BASE_8;
            NIB_LEAD_9: base = BASE_9;
            default:    base = BASE_E;
        endcase
        return base + {2'b00, lead[3:0], 8'h00} + {{(IDX_W-BYTE_W){1'b0}}, trail};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_lead();
        logic [3:0] nib;
        logic [3:0] lo;
        case ($urandom_range(2))
            0: nib = NIB_LEAD_8;
            1: nib = NIB_LEAD_9;
            default: nib = NIB_LEAD_E;
        endcase
        lo = 4'($urandom_range(15));
        return {nib, lo};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_single();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        while (b[7:4] == NIB_LEAD_8 || b[7:4] == NIB_LEAD_9 || b[7:4] == NIB_LEAD_E)
            b = BYTE_W'($urandom_range(255));
        return b;
    endfunction

    // make sure the entry a conversion reads holds a code point
    task automatic load_if_needed(input logic [IDX_W-1:0] idx);
        if (!table_loaded[idx] || $urandom_range(3) == 0)
            write_entry(idx, rand_cp());
    endtask

    task automatic random_char();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] trail;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            b = rand_single();
            load_if_needed({{(IDX_W-BYTE_W){1'b0}}, b});
            convert(b, $urandom_range(7) == 0);
        end else if (pick < 80) begin
            b     = rand_lead();
            trail = BYTE_W'($urandom_range(255));
            convert(b, 1'b0);
            load_if_needed(lead_index(b, trail));
            convert(trail, $urandom_range(3) == 0);
        end else if (pick < 88) begin
            convert(rand_lead(), 1'b1);
        end else begin
            write_entry(IDX_W'($urandom_range(16383)), CP_W'($urandom_range(65535)));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_operation     <= OP_CONVERT;
        i_byte_in       <= '0;
        i_end_of_stream <= 1'b0;
        i_entry_index   <= '0;
        i_entry_value   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 9;
        recv_stall_pct = 57;

        // single bytes at the utf8 length boundaries
        write_entry(14'h0000, 16'h0000);
        convert(8'h00, 1'b0);
        write_entry(14'h007F, 16'h007F);
        convert(8'h7F, 1'b0);
        write_entry(14'h00A0, 16'h0080);
        convert(8'hA0, 1'b0);
        write_entry(14'h00FF, 16'h07FF);
        convert(8'hFF, 1'b0);
        write_entry(14'h00DF, 16'h0800);
        convert(8'hDF, 1'b1);
        write_entry(14'h0020, 16'hFFFF);
        convert(8'h20, 1'b0);
        // lead/trail pairs, lowest and highest index
        write_entry(lead_index(8'h80, 8'h00), 16'h3042);
        convert(8'h80, 1'b0);
        convert(8'h00, 1'b0);
        // table write between lead and trail
        convert(8'h9F, 1'b0);
        write_entry(lead_index(8'h9F, 8'hFF), 16'h00E9);
        convert(8'hFF, 1'b0);
        write_entry(lead_index(8'hEF, 8'hFF), 16'hFFFF);
        convert(8'hEF, 1'b0);
        convert(8'hFF, 1'b1);
        // lead at end of stream is dropped
        convert(8'h85, 1'b1);
        convert(8'h7F, 1'b0);
        // trail that looks like a lead, with end of stream
        write_entry(lead_index(8'hE0, 8'h80), 16'h0041);
        convert(8'hE0, 1'b0);
        convert(8'h80, 1'b1);
        write_entry(14'h3FFF, 16'hFFFF);

        while (items_sent < 60) random_char();
        wait_drained();

        send_idle_pct  = 57;
        recv_stall_pct = 9;
        while (items_sent < 95) random_char();
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        while (items_sent < 115) random_char();
        wait_drained();
        while (items_sent < 130) random_char();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
